// ===== hw/rtl/prf_pkg.sv =====
package prf_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 63;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CUTOFF,
    CFG_MIN_DIST,
    CFG_MASS
  } cfg_reg_t;

  localparam logic [31:0] CUTOFF_RESET   = 32'd42949673;
  localparam logic [31:0] MIN_DIST_RESET = 32'd429497;
  localparam logic [31:0] MASS_RESET     = 32'd42949673;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  // per-request sideband carried down the pipe
  typedef struct packed {
    logic        react;
    logic        inr;
    logic        nx;
    logic        ny;
    logic [31:0] mx;
    logic [31:0] my;
  } side_t;

  typedef struct packed {
    logic [63:0] s;
    logic [33:0] rem;
    logic [31:0] root;
    side_t       side;
  } sqrt_t;

  typedef struct packed {
    logic [127:0] rem_x;
    logic [127:0] rem_y;
    logic [127:0] den;
    logic [62:0]  qx;
    logic [62:0]  qy;
    logic         satx;
    logic         saty;
    logic         zx;
    logic         zy;
    logic         negx;
    logic         negy;
    logic         react;
    logic         inr;
  } div_t;

endpackage

// ===== hw/rtl/prf_front.sv =====
module prf_front import prf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [47:0] self_x,
  input  logic signed [47:0] self_y,
  input  logic signed [47:0] other_x,
  input  logic signed [47:0] other_y,
  input  logic               react,
  input  logic [63:0]        c2,
  input  logic [63:0]        m2,
  output logic               out_valid,
  output sqrt_t              out_data
);

  logic [48:0] dx, dy, magx, magy;
  side_t       side1_nxt;
  logic        far1_nxt;

  logic        v1_r, far1_r;
  side_t       side1_r;
  logic        v2_r, far2_r;
  side_t       side2_r;
  logic [63:0] sx2_r, sy2_r;
  logic [64:0] sum;
  logic        outr;
  sqrt_t       data3_nxt;
  logic        v3_r;
  sqrt_t       data3_r;

  // differences and magnitudes
  always_comb begin
    dx = {other_x[47], other_x} - {self_x[47], self_x};
    dy = {other_y[47], other_y} - {self_y[47], self_y};
    magx = dx[48] ? (49'd0 - dx) : dx;
    magy = dy[48] ? (49'd0 - dy) : dy;
    far1_nxt = (|magx[48:32]) | (|magy[48:32]);
    side1_nxt.react = react;
    side1_nxt.inr   = 1'b0;
    side1_nxt.nx    = dx[48];
    side1_nxt.ny    = dy[48];
    side1_nxt.mx    = magx[31:0];
    side1_nxt.my    = magy[31:0];
  end

  // range test and clamp to min distance squared
  always_comb begin
    sum  = {1'b0, sx2_r} + {1'b0, sy2_r};
    outr = far2_r | sum[64] | (sum[63:0] > c2);
    data3_nxt.s    = (sum[63:0] < m2) ? m2 : sum[63:0];
    data3_nxt.rem  = '0;
    data3_nxt.root = '0;
    data3_nxt.side = side2_r;
    data3_nxt.side.inr = ~outr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side1_nxt;
      far1_r  <= far1_nxt;
      side2_r <= side1_r;
      far2_r  <= far1_r;
      sx2_r   <= 64'(side1_r.mx) * 64'(side1_r.mx);
      sy2_r   <= 64'(side1_r.my) * 64'(side1_r.my);
      data3_r <= data3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = data3_r;

endmodule

// ===== hw/rtl/prf_sqrt_step.sv =====
module prf_sqrt_step import prf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  sqrt_t      in_data,
  input  logic [1:0] pair,
  output logic       out_valid,
  output sqrt_t      out_data
);

  logic [35:0] cur, trial, diff;
  logic        ge;
  sqrt_t       data_nxt;
  logic        v_r;
  sqrt_t       data_r;

  // one root digit per stage
  always_comb begin
    cur   = {in_data.rem, pair};
    trial = {2'b00, in_data.root, 2'b01};
    ge    = cur >= trial;
    diff  = cur - trial;
    data_nxt      = in_data;
    data_nxt.rem  = ge ? diff[33:0] : cur[33:0];
    data_nxt.root = {in_data.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

// ===== hw/rtl/prf_scale.sv =====
module prf_scale import prf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  sqrt_t       in_data,
  input  logic [31:0] cutoff,
  input  logic [31:0] mass,
  output logic        out_valid,
  output div_t        out_data
);

  logic        na1_nxt;
  logic [31:0] a1_nxt;
  logic        v1_r, na1_r;
  side_t       side1_r;
  logic [31:0] a1_r;
  logic [63:0] slr1_r, shr1_r;

  logic        v2_r, na2_r;
  side_t       side2_r;
  logic [95:0] sr2_r;
  logic [63:0] px2_r, py2_r;

  logic        v3_r, na3_r;
  side_t       side3_r;
  logic [63:0] px3_r, py3_r, p0_r, p1_r, p2_r;

  logic [127:0] den;
  div_t         data4_nxt;
  logic         v4_r;
  div_t         data4_r;

  // distance minus cutoff
  always_comb begin
    na1_nxt = in_data.root < cutoff;
    a1_nxt  = na1_nxt ? (cutoff - in_data.root) : (in_data.root - cutoff);
  end

  // denominator, saturation test and divider seed
  always_comb begin
    den = {64'd0, p0_r} + {32'd0, p1_r, 32'd0} + {p2_r, 64'd0};
    data4_nxt.den   = den;
    data4_nxt.rem_x = {47'd0, px3_r, 17'd0};
    data4_nxt.rem_y = {47'd0, py3_r, 17'd0};
    data4_nxt.satx  = {47'd0, px3_r, 17'd0} >= den;
    data4_nxt.saty  = {47'd0, py3_r, 17'd0} >= den;
    data4_nxt.zx    = px3_r == 64'd0;
    data4_nxt.zy    = py3_r == 64'd0;
    data4_nxt.negx  = na3_r ^ side3_r.nx;
    data4_nxt.negy  = na3_r ^ side3_r.ny;
    data4_nxt.qx    = '0;
    data4_nxt.qy    = '0;
    data4_nxt.react = side3_r.react;
    data4_nxt.inr   = side3_r.inr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= in_data.side;
      na1_r   <= na1_nxt;
      a1_r    <= a1_nxt;
      slr1_r  <= 64'(in_data.s[31:0]) * 64'(in_data.root);
      shr1_r  <= 64'(in_data.s[63:32]) * 64'(in_data.root);

      side2_r <= side1_r;
      na2_r   <= na1_r;
      sr2_r   <= {shr1_r, 32'd0} + {32'd0, slr1_r};
      px2_r   <= 64'(a1_r) * 64'(side1_r.mx);
      py2_r   <= 64'(a1_r) * 64'(side1_r.my);

      side3_r <= side2_r;
      na3_r   <= na2_r;
      px3_r   <= px2_r;
      py3_r   <= py2_r;
      p0_r    <= 64'(sr2_r[31:0]) * 64'(mass);
      p1_r    <= 64'(sr2_r[63:32]) * 64'(mass);
      p2_r    <= 64'(sr2_r[95:64]) * 64'(mass);

      data4_r <= data4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = data4_r;

endmodule

// ===== hw/rtl/prf_div_step.sv =====
module prf_div_step import prf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic [128:0] tx, ty, dd, rx, ry;
  logic         gx, gy;
  div_t         data_nxt;
  logic         v_r;
  div_t         data_r;

  // one quotient bit per lane per stage
  always_comb begin
    tx = {in_data.rem_x, 1'b0};
    ty = {in_data.rem_y, 1'b0};
    dd = {1'b0, in_data.den};
    gx = tx >= dd;
    gy = ty >= dd;
    rx = gx ? (tx - dd) : tx;
    ry = gy ? (ty - dd) : ty;
    data_nxt       = in_data;
    data_nxt.rem_x = rx[127:0];
    data_nxt.rem_y = ry[127:0];
    data_nxt.qx    = {in_data.qx[61:0], gx};
    data_nxt.qy    = {in_data.qy[61:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = data_r;

endmodule

// ===== hw/rtl/pair_repulsion_force_top.sv =====
// pipeline from an accepted request to out_valid: 3 front, 32 root, 4 scale, 63 divide
//   stages and 1 output register
// throughput: one request per cycle; the pipe stalls only when its last stage holds a
//   result and the output register is full and not taken
// reset: synchronous active-low rst_n empties every stage and restores register defaults
module pair_repulsion_force_top import prf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [47:0] in_self_x,
  input  logic signed [47:0] in_self_y,
  input  logic signed [47:0] in_other_x,
  input  logic signed [47:0] in_other_y,
  input  logic               in_apply_reaction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_self_dax,
  output logic signed [63:0] out_self_day,
  output logic signed [63:0] out_other_dax,
  output logic signed [63:0] out_other_day,
  output logic               out_in_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration registers and their squares
  logic [31:0] cutoff_r, min_dist_r, mass_r;
  logic [63:0] c2_r, m2_r;

  // global advance: free unless the tail holds a result that cannot leave
  logic en;

  logic  sq_v [0:SQRT_STEPS];
  sqrt_t sq_d [0:SQRT_STEPS];
  logic  dv_v [0:DIV_STEPS];
  div_t  dv_d [0:DIV_STEPS];

  logic        out_valid_r, in_range_r;
  logic [63:0] self_dax_r, self_day_r, other_dax_r, other_day_r;
  logic [63:0] self_dax_nxt, self_day_nxt, other_dax_nxt, other_day_nxt;
  logic        in_range_nxt;

  assign cfg_ready = 1'b1;
  assign en        = ~dv_v[DIV_STEPS] | ~out_valid_r | out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r   <= CUTOFF_RESET;
      min_dist_r <= MIN_DIST_RESET;
      mass_r     <= MASS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CUTOFF:   cutoff_r   <= cfg_data;
        CFG_MIN_DIST: min_dist_r <= cfg_data;
        CFG_MASS:     mass_r     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // squares are registered in the cycle after a write, before a request accepted with it reaches the range test
  always_ff @(posedge clk) begin
    c2_r <= 64'(cutoff_r) * 64'(cutoff_r);
    m2_r <= 64'(min_dist_r) * 64'(min_dist_r);
  end

  // deltas, squared distance, range test and clamp
  prf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .self_x    (in_self_x),
    .self_y    (in_self_y),
    .other_x   (in_other_x),
    .other_y   (in_other_y),
    .react     (in_apply_reaction),
    .c2        (c2_r),
    .m2        (m2_r),
    .out_valid (sq_v[0]),
    .out_data  (sq_d[0])
  );

  // floor square root, one digit per stage, most significant bit pair first
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    prf_sqrt_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[k]),
      .in_data   (sq_d[k]),
      .pair      (sq_d[k].s[(62 - 2 * k) +: 2]),
      .out_valid (sq_v[k + 1]),
      .out_data  (sq_d[k + 1])
    );
  end

  // numerators a*|d|, denominator s*r*mass, saturation test
  prf_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v[SQRT_STEPS]),
    .in_data   (sq_d[SQRT_STEPS]),
    .cutoff    (cutoff_r),
    .mass      (mass_r),
    .out_valid (dv_v[0]),
    .out_data  (dv_d[0])
  );

  // restoring division, 63 quotient bits, both axes side by side
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    prf_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k + 1]),
      .out_data  (dv_d[k + 1])
    );
  end

  // sign, saturation and neighbour value for one axis: {self, other}
  function automatic logic [127:0] lane_out(input logic sat, input logic zero,
                                            input logic neg, input logic [62:0] q,
                                            input logic react);
    logic [63:0] mag, self_v, other_v;
    mag = {1'b0, q};
    if (zero) begin
      self_v  = '0;
      other_v = '0;
    end else if (sat) begin
      self_v  = neg ? NEG_MIN : POS_MAX;
      other_v = neg ? POS_MAX : (64'd0 - POS_MAX);
    end else begin
      self_v  = neg ? (64'd0 - mag) : mag;
      other_v = neg ? mag : (64'd0 - mag);
    end
    if (!react) begin
      other_v = '0;
    end
    return {self_v, other_v};
  endfunction

  always_comb begin
    {self_dax_nxt, other_dax_nxt} = lane_out(dv_d[DIV_STEPS].satx, dv_d[DIV_STEPS].zx,
                                             dv_d[DIV_STEPS].negx, dv_d[DIV_STEPS].qx,
                                             dv_d[DIV_STEPS].react);
    {self_day_nxt, other_day_nxt} = lane_out(dv_d[DIV_STEPS].saty, dv_d[DIV_STEPS].zy,
                                             dv_d[DIV_STEPS].negy, dv_d[DIV_STEPS].qy,
                                             dv_d[DIV_STEPS].react);
    in_range_nxt = dv_d[DIV_STEPS].inr;
    // out of range: everything zero
    if (!dv_d[DIV_STEPS].inr) begin
      self_dax_nxt  = '0;
      self_day_nxt  = '0;
      other_dax_nxt = '0;
      other_day_nxt = '0;
    end
  end

  // output register parts the pipe from the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      out_valid_r <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      self_dax_r  <= self_dax_nxt;
      self_day_r  <= self_day_nxt;
      other_dax_r <= other_dax_nxt;
      other_day_r <= other_day_nxt;
      in_range_r  <= in_range_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_self_dax  = $signed(self_dax_r);
  assign out_self_day  = $signed(self_day_r);
  assign out_other_dax = $signed(other_dax_r);
  assign out_other_day = $signed(other_day_r);
  assign out_in_range  = in_range_r;

  // an out-of-range result carries no increments
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |->
      out_self_dax == 64'sd0 && out_self_day == 64'sd0 &&
      out_other_dax == 64'sd0 && out_other_day == 64'sd0)
    else $error("out-of-range result has nonzero increments");

  // the neighbour x increment mirrors the particle x increment unless that is saturated negative
  a_reaction_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_other_dax != 64'sd0 && out_self_dax != $signed(NEG_MIN) |->
      out_other_dax == -out_self_dax)
    else $error("neighbour x increment does not mirror particle increment");

  // the pipe only holds back when a finished result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && dv_v[DIV_STEPS])
    else $error("input stalled without a blocked result");

  // a result blocked at the output keeps the tail of the pipe occupied
  a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> dv_v[DIV_STEPS])
    else $error("tail stage lost its result during a stall");

endmodule
